// File: rtl/core/primitive_assembly_triangulator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the primitive assembly triangulator
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLY_TRIANGULATOR_DEFINES_SVH
`define PRIMITIVE_ASSEMBLY_TRIANGULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pat_pkg.sv
// ----------------------------------------------------------------------------
// Primitive assembly triangulator package
// Vertex and triangle types, topology codes and sizing constants.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int unsigned HELD_VERTICES = 3;
  localparam int unsigned JOB_VERTICES  = 4;
  localparam int unsigned JOB_TRIANGLES = 2;

  typedef enum logic [2:0] {
    TOPO_QUADS      = 3'd0,
    TOPO_QUAD_STRIP = 3'd1,
    TOPO_TRIANGLES  = 3'd2,
    TOPO_TRI_STRIP  = 3'd3,
    TOPO_TRI_FAN    = 3'd4
  } topology_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] rgba;
  } vertex_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } triangle_t;

endpackage

// File: rtl/core/primitive_assembly_triangulator.sv
// ----------------------------------------------------------------------------
// Primitive assembly triangulator
// Groups incoming vertices by topology and emits vertex and index words.
// ----------------------------------------------------------------------------
// Each accepted vertex updates the path state in the cycle it is taken and,
// when it completes a group, loads a job of up to four vertex words and two
// triangle words. The single result port sends one word per cycle unless
// out_stall holds it. A job holds 6 words for quads and quad strip, 4 for
// triangles and the first strip or fan triangle, and 2 for later ones; a
// vertex that only waits in the holding slots sends no words. A new vertex
// is taken in the same cycle as the last word of the current job. On a quad
// strip the vertex that only waits is taken with that last word, and the
// vertex that completes the next quad is taken in the following cycle with
// no word out. Configuration writes are always ready.
module primitive_assembly_triangulator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_topology,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             in_pos_x,
  input  logic [31:0]             in_pos_y,
  input  logic [31:0]             in_tex_u,
  input  logic [31:0]             in_tex_v,
  input  logic [31:0]             in_rgba,
  input  logic                    in_end_of_primitive,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [31:0]             out_x,
  output logic [31:0]             out_y,
  output logic [31:0]             out_u,
  output logic [31:0]             out_v,
  output logic [31:0]             out_rgba,
  output logic [31:0]             out_index_a,
  output logic [31:0]             out_index_b,
  output logic [31:0]             out_index_c,
  output logic                    out_run_last
);
  import pat_pkg::*;

  `include "primitive_assembly_triangulator_defines.svh"

  logic [2:0]  topology_r, topology_nxt;
  vertex_t     held_r [HELD_VERTICES];
  vertex_t     held_nxt [HELD_VERTICES];
  logic [31:0] cursor_r, cursor_nxt;
  logic [31:0] base_r, base_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  warm_r, warm_nxt;
  logic        odd_r, odd_nxt;

  vertex_t     job_vert_r [JOB_VERTICES];
  vertex_t     job_vert_nxt [JOB_VERTICES];
  triangle_t   job_tri_r [JOB_TRIANGLES];
  triangle_t   job_tri_nxt [JOB_TRIANGLES];
  logic [2:0]  job_nvert_r, job_nvert_nxt;
  logic [2:0]  job_nres_r, job_nres_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;

  logic        in_fire, out_fire, cfg_fire, job_last, load_job;
  vertex_t     vin;
  logic [31:0] b1, b2, b3, cm1, cm2;
  logic [2:0]  tri_sel;
  vertex_t     cur_vert;
  triangle_t   cur_tri;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign job_last  = (step_r == (job_nres_r - 3'd1));
  assign out_valid = busy_r;
  assign out_fire  = busy_r && !out_stall;
  // The next vertex may enter while the last word of the job leaves.
  assign in_stall  = busy_r && !(out_fire && job_last);
  assign in_fire   = in_valid && !in_stall;

  assign vin = '{x: in_pos_x, y: in_pos_y, u: in_tex_u, v: in_tex_v, rgba: in_rgba};

  assign b1  = cursor_r + 32'd1;
  assign b2  = cursor_r + 32'd2;
  assign b3  = cursor_r + 32'd3;
  assign cm1 = cursor_r - 32'd1;
  assign cm2 = cursor_r - 32'd2;

  always_comb begin
    topology_nxt  = topology_r;
    held_nxt      = held_r;
    cursor_nxt    = cursor_r;
    base_nxt      = base_r;
    phase_nxt     = phase_r;
    warm_nxt      = warm_r;
    odd_nxt       = odd_r;
    job_vert_nxt  = job_vert_r;
    job_tri_nxt   = job_tri_r;
    job_nvert_nxt = job_nvert_r;
    job_nres_nxt  = job_nres_r;
    load_job      = 1'b0;

    if (in_fire) begin
      unique case (topology_r)
        TOPO_QUADS, TOPO_QUAD_STRIP: begin
          if (phase_r != 2'd3) begin
            held_nxt[phase_r] = vin;
            phase_nxt         = phase_r + 2'd1;
          end else begin
            load_job        = 1'b1;
            job_vert_nxt[0] = held_r[0];
            job_vert_nxt[1] = held_r[1];
            job_vert_nxt[2] = held_r[2];
            job_vert_nxt[3] = vin;
            job_nvert_nxt   = 3'd4;
            job_nres_nxt    = 3'd6;
            base_nxt        = cursor_r;
            cursor_nxt      = cursor_r + 32'd4;
            if (topology_r == TOPO_QUADS) begin
              job_tri_nxt[0] = '{a: cursor_r, b: b1, c: b2};
              job_tri_nxt[1] = '{a: cursor_r, b: b2, c: b3};
              phase_nxt      = 2'd0;
            end else begin
              // The second pair of the quad becomes the first of the next.
              job_tri_nxt[0] = '{a: cursor_r, b: b1, c: b3};
              job_tri_nxt[1] = '{a: cursor_r, b: b3, c: b2};
              held_nxt[0]    = held_r[2];
              held_nxt[1]    = vin;
              phase_nxt      = 2'd2;
            end
          end
        end
        TOPO_TRIANGLES: begin
          if (phase_r < 2'd2) begin
            held_nxt[phase_r] = vin;
            phase_nxt         = phase_r + 2'd1;
          end else begin
            load_job        = 1'b1;
            job_vert_nxt[0] = held_r[0];
            job_vert_nxt[1] = held_r[1];
            job_vert_nxt[2] = vin;
            job_tri_nxt[0]  = '{a: cursor_r, b: b1, c: b2};
            job_nvert_nxt   = 3'd3;
            job_nres_nxt    = 3'd4;
            base_nxt        = cursor_r;
            cursor_nxt      = b3;
            phase_nxt       = 2'd0;
          end
        end
        TOPO_TRI_STRIP, TOPO_TRI_FAN: begin
          if (warm_r < 2'd2) begin
            held_nxt[warm_r] = vin;
            warm_nxt         = warm_r + 2'd1;
          end else if (warm_r == 2'd2) begin
            load_job        = 1'b1;
            job_vert_nxt[0] = held_r[0];
            job_vert_nxt[1] = held_r[1];
            job_vert_nxt[2] = vin;
            job_tri_nxt[0]  = '{a: cursor_r, b: b1, c: b2};
            job_nvert_nxt   = 3'd3;
            job_nres_nxt    = 3'd4;
            base_nxt        = cursor_r;
            cursor_nxt      = b3;
            odd_nxt         = 1'b1;
            warm_nxt        = 2'd3;
          end else begin
            // Steady state: one new vertex and one triangle ending at it.
            load_job        = 1'b1;
            job_vert_nxt[0] = vin;
            job_nvert_nxt   = 3'd1;
            job_nres_nxt    = 3'd2;
            cursor_nxt      = b1;
            odd_nxt         = !odd_r;
            if (topology_r == TOPO_TRI_FAN) begin
              job_tri_nxt[0] = '{a: base_r, b: cm1, c: cursor_r};
            end else if (odd_r) begin
              job_tri_nxt[0] = '{a: cm1, b: cm2, c: cursor_r};
            end else begin
              job_tri_nxt[0] = '{a: cm2, b: cm1, c: cursor_r};
            end
          end
        end
        default: begin
        end
      endcase

      if (in_end_of_primitive) begin
        phase_nxt = 2'd0;
        warm_nxt  = 2'd0;
        odd_nxt   = 1'b0;
      end
    end

    // A topology change drops whatever path is in progress.
    if (cfg_fire) begin
      topology_nxt = cfg_topology;
      phase_nxt    = 2'd0;
      warm_nxt     = 2'd0;
      odd_nxt      = 1'b0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (load_job) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
    end else if (out_fire && job_last) begin
      busy_nxt = 1'b0;
      step_nxt = 3'd0;
    end else if (out_fire) begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topology_r  <= TOPO_QUADS;
      cursor_r    <= '0;
      base_r      <= '0;
      phase_r     <= '0;
      warm_r      <= '0;
      odd_r       <= 1'b0;
      job_nvert_r <= '0;
      job_nres_r  <= '0;
      step_r      <= '0;
      busy_r      <= 1'b0;
    end else begin
      topology_r  <= topology_nxt;
      cursor_r    <= cursor_nxt;
      base_r      <= base_nxt;
      phase_r     <= phase_nxt;
      warm_r      <= warm_nxt;
      odd_r       <= odd_nxt;
      job_nvert_r <= job_nvert_nxt;
      job_nres_r  <= job_nres_nxt;
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    job_vert_r <= job_vert_nxt;
    job_tri_r  <= job_tri_nxt;
  end

  // Vertex words come first in a job, then its triangle words.
  assign tri_sel  = step_r - job_nvert_r;
  assign cur_vert = job_vert_r[step_r[1:0]];
  assign cur_tri  = job_tri_r[tri_sel[0]];

  always_comb begin
    out_kind    = 1'b0;
    out_x       = '0;
    out_y       = '0;
    out_u       = '0;
    out_v       = '0;
    out_rgba    = '0;
    out_index_a = '0;
    out_index_b = '0;
    out_index_c = '0;
    if (step_r < job_nvert_r) begin
      out_x    = cur_vert.x;
      out_y    = cur_vert.y;
      out_u    = cur_vert.u;
      out_v    = cur_vert.v;
      out_rgba = cur_vert.rgba;
    end else begin
      out_kind    = 1'b1;
      out_index_a = cur_tri.a;
      out_index_b = cur_tri.b;
      out_index_c = cur_tri.c;
    end
  end

  assign out_run_last = job_last;

  `PAT_ASSERT_SAME(a_step_in_job, busy_r, step_r < job_nres_r,
    "Result step beyond the end of its job.")
  `PAT_ASSERT_SAME(a_accept_while_busy, busy_r && in_fire, out_fire && job_last,
    "Vertex word taken while the current job still has words to send.")
  `PAT_ASSERT_NEXT(a_step_restart, out_fire && job_last, step_r == 3'd0,
    "Step did not return to zero after the last word of a job.")
  `PAT_ASSERT_NEXT(a_cursor_hold, !in_fire, $stable(cursor_r),
    "Vertex cursor moved without an accepted vertex word.")

endmodule
